// ----- hdl/v3a_pkg.sv -----
// Shared types and constants of the three-component vector unit.
// No dependencies; every other file of the block but v3a_delay refers to it by scoped names.
package v3a_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_SCALE = 3'd2,
        OP_DIV   = 3'd3,
        OP_DOT   = 3'd4,
        OP_CROSS = 3'd5,
        OP_LEN   = 3'd6
    } v3a_op_t;

    typedef struct packed {
        logic              ovf;
        logic signed [31:0] val;
    } v3a_sat_t;

    typedef struct packed {
        v3a_op_t            op;
        logic               dz;
        logic               ovf;
        logic signed [31:0] res_x;
        logic signed [31:0] res_y;
        logic signed [31:0] res_z;
        logic signed [31:0] res_scalar;
    } v3a_res_t;

endpackage

// ----- hdl/v3a_delay.sv -----
// Enable-gated delay line used to align results of the short paths.
// No dependencies.
module v3a_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] stage_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                stage_reg[i] <= stage_reg[i-1];
            end
        end
    end

    assign q = stage_reg[DEPTH-1];

endmodule

// ----- hdl/v3a_prod.sv -----
// Product path: six shared 32x32 multipliers, combine adders, round and saturate.
// Three register stages; depends on v3a_pkg.
module v3a_prod #(
    parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                en,
    input  v3a_pkg::v3a_op_t    op,
    input  logic signed [31:0]  a [3],
    input  logic signed [31:0]  b [3],
    input  logic signed [31:0]  scale_factor,
    output logic [63:0]         sq_sum,
    output logic signed [31:0]  rnd_x,
    output logic signed [31:0]  rnd_y,
    output logic signed [31:0]  rnd_z,
    output logic signed [31:0]  rnd_scalar,
    output logic                rnd_ovf
);

    localparam int SUM_W = 67;
    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (FRAC_BITS - 1);

    logic signed [31:0]      ma [6];
    logic signed [31:0]      mb [6];
    logic signed [63:0]      p_reg [6];
    v3a_pkg::v3a_op_t        op2_reg;
    v3a_pkg::v3a_op_t        op3_reg;
    logic signed [SUM_W-1:0] sx_next, sy_next, sz_next;
    logic signed [SUM_W-1:0] sx_reg, sy_reg, sz_reg;
    v3a_pkg::v3a_sat_t       rx, ry, rz;
    logic signed [31:0]      rnd_x_next, rnd_y_next, rnd_z_next, rnd_scalar_next;
    logic                    rnd_ovf_next;
    logic signed [31:0]      rnd_x_reg, rnd_y_reg, rnd_z_reg, rnd_scalar_reg;
    logic                    rnd_ovf_reg;

    function automatic v3a_pkg::v3a_sat_t rsat(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] t;
        v3a_pkg::v3a_sat_t       r;
        t     = (v + HALF) >>> FRAC_BITS;
        r.ovf = !((&t[SUM_W-1:31]) || !(|t[SUM_W-1:31]));
        if (r.ovf)
        begin
            r.val = t[SUM_W-1] ? v3a_pkg::S32_MIN : v3a_pkg::S32_MAX;
        end
        else
        begin
            r.val = t[31:0];
        end
        return r;
    endfunction

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            ma[i] = a[i % 3];
            mb[i] = b[i % 3];
        end
        case (op)
            v3a_pkg::OP_SCALE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mb[i] = scale_factor;
                end
            end
            v3a_pkg::OP_CROSS:
            begin
                ma[0] = a[1]; mb[0] = b[2];
                ma[1] = a[2]; mb[1] = b[1];
                ma[2] = a[2]; mb[2] = b[0];
                ma[3] = a[0]; mb[3] = b[2];
                ma[4] = a[0]; mb[4] = b[1];
                ma[5] = a[1]; mb[5] = b[0];
            end
            v3a_pkg::OP_LEN:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mb[i] = a[i];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 6; i++)
            begin
                p_reg[i] <= ma[i] * mb[i];
            end
            op2_reg <= op;
        end
    end

    always_comb
    begin
        sx_next = '0;
        sy_next = '0;
        sz_next = '0;
        case (op2_reg)
            v3a_pkg::OP_SCALE:
            begin
                sx_next = SUM_W'(p_reg[0]);
                sy_next = SUM_W'(p_reg[1]);
                sz_next = SUM_W'(p_reg[2]);
            end
            v3a_pkg::OP_DOT, v3a_pkg::OP_LEN:
            begin
                sx_next = SUM_W'(p_reg[0]) + SUM_W'(p_reg[1]) + SUM_W'(p_reg[2]);
            end
            v3a_pkg::OP_CROSS:
            begin
                sx_next = SUM_W'(p_reg[0]) - SUM_W'(p_reg[1]);
                sy_next = SUM_W'(p_reg[2]) - SUM_W'(p_reg[3]);
                sz_next = SUM_W'(p_reg[4]) - SUM_W'(p_reg[5]);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg  <= sx_next;
            sy_reg  <= sy_next;
            sz_reg  <= sz_next;
            op3_reg <= op2_reg;
        end
    end

    assign sq_sum = sx_reg[63:0];

    always_comb
    begin
        rx = rsat(sx_reg);
        ry = rsat(sy_reg);
        rz = rsat(sz_reg);
        rnd_x_next      = '0;
        rnd_y_next      = '0;
        rnd_z_next      = '0;
        rnd_scalar_next = '0;
        rnd_ovf_next    = 1'b0;
        case (op3_reg)
            v3a_pkg::OP_SCALE, v3a_pkg::OP_CROSS:
            begin
                rnd_x_next   = rx.val;
                rnd_y_next   = ry.val;
                rnd_z_next   = rz.val;
                rnd_ovf_next = rx.ovf | ry.ovf | rz.ovf;
            end
            v3a_pkg::OP_DOT:
            begin
                rnd_scalar_next = rx.val;
                rnd_ovf_next    = rx.ovf;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rnd_x_reg      <= rnd_x_next;
            rnd_y_reg      <= rnd_y_next;
            rnd_z_reg      <= rnd_z_next;
            rnd_scalar_reg <= rnd_scalar_next;
            rnd_ovf_reg    <= rnd_ovf_next;
        end
    end

    assign rnd_x      = rnd_x_reg;
    assign rnd_y      = rnd_y_reg;
    assign rnd_z      = rnd_z_reg;
    assign rnd_scalar = rnd_scalar_reg;
    assign rnd_ovf    = rnd_ovf_reg;

endmodule

// ----- hdl/v3a_div.sv -----
// Pipelined restoring divider for one component: one quotient bit per stage,
// rounding to nearest and Q16.16 saturation; depends on v3a_pkg.
module v3a_div #(
    parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] a,
    input  logic signed [31:0] divisor,
    output logic signed [31:0] q,
    output logic               ovf
);

    localparam int W = 32 + FRAC_BITS;

    logic [31:0]        mag_a, mag_d;
    logic [31:0]        rem_reg [W+1];
    logic [W-1:0]       dq_reg  [W+1];
    logic [31:0]        dv_reg  [W+1];
    logic               neg_reg [W+1];
    logic [W-1:0]       quo;
    logic               big;
    logic signed [31:0] q_next, q_reg;
    logic               ovf_next, ovf_reg;

    assign mag_a = a[31] ? 32'(-a) : 32'(a);
    assign mag_d = divisor[31] ? 32'(-divisor) : 32'(divisor);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= '0;
            dq_reg[0]  <= (W'(mag_a) << FRAC_BITS) + W'(mag_d >> 1);
            dv_reg[0]  <= mag_d;
            neg_reg[0] <= a[31] ^ divisor[31];
        end
    end

    for (genvar k = 0; k < W; k++)
    begin : g_step
        logic [32:0] rt, rn;
        logic        ge;

        always_comb
        begin
            rt = {rem_reg[k], dq_reg[k][W-1]};
            ge = rt >= {1'b0, dv_reg[k]};
            rn = ge ? rt - {1'b0, dv_reg[k]} : rt;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= rn[31:0];
                dq_reg[k+1]  <= {dq_reg[k][W-2:0], ge};
                dv_reg[k+1]  <= dv_reg[k];
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    always_comb
    begin
        quo = dq_reg[W];
        big = |quo[W-1:32];
        if (neg_reg[W])
        begin
            ovf_next = big | (quo[31] & (|quo[30:0]));
            q_next   = ovf_next ? v3a_pkg::S32_MIN : 32'(-quo[31:0]);
        end
        else
        begin
            ovf_next = big | quo[31];
            q_next   = ovf_next ? v3a_pkg::S32_MAX : quo[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg   <= q_next;
            ovf_reg <= ovf_next;
        end
    end

    assign q   = q_reg;
    assign ovf = ovf_reg;

endmodule

// ----- hdl/v3a_sqrt.sv -----
// Pipelined digit-by-digit square root of a 64-bit sum of squares, two radicand
// bits per stage, rounding to nearest and saturation; depends on v3a_pkg.
module v3a_sqrt (
    input  logic               clk,
    input  logic               en,
    input  logic [63:0]        sq,
    output logic signed [31:0] len,
    output logic               ovf
);

    localparam int STEPS = 32;

    logic [33:0]        rem_reg  [STEPS+1];
    logic [31:0]        root_reg [STEPS+1];
    logic [63:0]        rad_reg  [STEPS+1];
    logic               inc;
    logic [32:0]        r33;
    logic signed [31:0] len_next, len_reg;
    logic               ovf_next, ovf_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            rad_reg[0]  <= sq;
        end
    end

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic [35:0] rt, trial, rn;
        logic        ge;

        always_comb
        begin
            rt    = {rem_reg[k], rad_reg[k][63:62]};
            trial = {2'b00, root_reg[k], 2'b01};
            ge    = rt >= trial;
            rn    = ge ? rt - trial : rt;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= rn[33:0];
                root_reg[k+1] <= {root_reg[k][30:0], ge};
                rad_reg[k+1]  <= {rad_reg[k][61:0], 2'b00};
            end
        end
    end

    always_comb
    begin
        inc      = rem_reg[STEPS] > {2'b00, root_reg[STEPS]};
        r33      = {1'b0, root_reg[STEPS]} + 33'(inc);
        ovf_next = r33[32] | r33[31];
        len_next = ovf_next ? v3a_pkg::S32_MAX : r33[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len_reg <= len_next;
            ovf_reg <= ovf_next;
        end
    end

    assign len = len_reg;
    assign ovf = ovf_reg;

endmodule

// ----- hdl/vector3_alu_unit.sv -----
// Three-component vector unit in signed fixed point (Q16.16 by default): add,
// subtract, scale, divide, dot, cross and length. One beat in, one beat out.
// Depends on v3a_pkg, v3a_prod, v3a_div, v3a_sqrt and v3a_delay.
//
// Fully pipelined: a new beat is taken every cycle while the pipeline is not
// held, and results leave in input order. The divider sets the depth: it
// resolves one quotient bit per stage over 32 + FRAC_BITS stages, and all
// other operations are delayed to match it. The whole pipeline advances
// together and holds while a finished result waits on res_ready, so ready
// follows !res_valid || res_ready.
module vector3_alu_unit #(
    parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid,
    output logic               ready,
    input  logic [2:0]         opcode,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] a_z,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic signed [31:0] b_z,
    input  logic signed [31:0] scale_factor,
    output logic               res_valid,
    input  logic               res_ready,
    output logic signed [31:0] res_x,
    output logic signed [31:0] res_y,
    output logic signed [31:0] res_z,
    output logic signed [31:0] res_scalar,
    output logic               div_zero,
    output logic               overflow
);

    localparam int DIV_W    = 32 + FRAC_BITS;
    localparam int MERGE    = DIV_W + 2;
    localparam int RES_W    = $bits(v3a_pkg::v3a_res_t);
    localparam int SQ_DELAY = FRAC_BITS - 2;

    logic                en;
    logic [MERGE:0]      vld_reg;
    logic                res_valid_reg;

    v3a_pkg::v3a_op_t    op1_reg;
    logic signed [31:0]  a1_reg [3];
    logic signed [31:0]  b1_reg [3];
    logic signed [31:0]  s1_reg;

    v3a_pkg::v3a_sat_t   lane [3];
    logic [32:0]         sum33, dif33;
    v3a_pkg::v3a_res_t   early_next, early3_reg, early4_reg, early2_reg;
    v3a_pkg::v3a_res_t   fast;
    v3a_pkg::v3a_res_t   fd;
    logic [RES_W-1:0]    fd_vec;

    logic [63:0]         sq_sum, sq_dly;
    logic signed [31:0]  rnd_x, rnd_y, rnd_z, rnd_scalar;
    logic                rnd_ovf;
    logic signed [31:0]  dq [3];
    logic                dovf [3];
    logic signed [31:0]  len;
    logic                len_ovf;

    v3a_pkg::v3a_res_t   out_next, out_reg;

    function automatic v3a_pkg::v3a_sat_t sat33(input logic [32:0] v);
        v3a_pkg::v3a_sat_t r;
        r.ovf = v[32] ^ v[31];
        if (r.ovf)
        begin
            r.val = v[32] ? v3a_pkg::S32_MIN : v3a_pkg::S32_MAX;
        end
        else
        begin
            r.val = v[31:0];
        end
        return r;
    endfunction

    assign en    = !res_valid_reg || res_ready;
    assign ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[MERGE-1:0], valid};
            res_valid_reg <= vld_reg[MERGE];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op1_reg   <= v3a_pkg::v3a_op_t'(opcode);
            a1_reg[0] <= a_x;
            a1_reg[1] <= a_y;
            a1_reg[2] <= a_z;
            b1_reg[0] <= b_x;
            b1_reg[1] <= b_y;
            b1_reg[2] <= b_z;
            s1_reg    <= scale_factor;
        end
    end

    always_comb
    begin
        sum33 = '0;
        dif33 = '0;
        for (int i = 0; i < 3; i++)
        begin
            sum33   = {a1_reg[i][31], a1_reg[i]} + {b1_reg[i][31], b1_reg[i]};
            dif33   = {a1_reg[i][31], a1_reg[i]} - {b1_reg[i][31], b1_reg[i]};
            lane[i] = '0;
            case (op1_reg)
                v3a_pkg::OP_ADD: lane[i] = sat33(sum33);
                v3a_pkg::OP_SUB: lane[i] = sat33(dif33);
                v3a_pkg::OP_DIV:
                begin
                    if (s1_reg == '0)
                    begin
                        lane[i].val = a1_reg[i];
                    end
                end
                default:
                begin
                end
            endcase
        end
        early_next            = '0;
        early_next.op         = op1_reg;
        early_next.dz         = (op1_reg == v3a_pkg::OP_DIV) && (s1_reg == '0);
        early_next.ovf        = lane[0].ovf | lane[1].ovf | lane[2].ovf;
        early_next.res_x      = lane[0].val;
        early_next.res_y      = lane[1].val;
        early_next.res_z      = lane[2].val;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            early2_reg <= early_next;
            early3_reg <= early2_reg;
            early4_reg <= early3_reg;
        end
    end

    v3a_prod #(
        .FRAC_BITS (FRAC_BITS)
    ) u_prod (
        .clk          (clk),
        .en           (en),
        .op           (op1_reg),
        .a            (a1_reg),
        .b            (b1_reg),
        .scale_factor (s1_reg),
        .sq_sum       (sq_sum),
        .rnd_x        (rnd_x),
        .rnd_y        (rnd_y),
        .rnd_z        (rnd_z),
        .rnd_scalar   (rnd_scalar),
        .rnd_ovf      (rnd_ovf)
    );

    always_comb
    begin
        fast = early4_reg;
        case (early4_reg.op)
            v3a_pkg::OP_SCALE, v3a_pkg::OP_DOT, v3a_pkg::OP_CROSS:
            begin
                fast.res_x      = rnd_x;
                fast.res_y      = rnd_y;
                fast.res_z      = rnd_z;
                fast.res_scalar = rnd_scalar;
                fast.ovf        = rnd_ovf;
            end
            default:
            begin
            end
        endcase
    end

    v3a_delay #(
        .WIDTH (RES_W),
        .DEPTH (DIV_W - 1)
    ) u_fast_dly (
        .clk (clk),
        .en  (en),
        .d   (fast),
        .q   (fd_vec)
    );

    assign fd = v3a_pkg::v3a_res_t'(fd_vec);

    for (genvar i = 0; i < 3; i++)
    begin : g_div
        v3a_div #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .clk     (clk),
            .en      (en),
            .a       (a1_reg[i]),
            .divisor (s1_reg),
            .q       (dq[i]),
            .ovf     (dovf[i])
        );
    end

    v3a_delay #(
        .WIDTH (64),
        .DEPTH (SQ_DELAY)
    ) u_sq_dly (
        .clk (clk),
        .en  (en),
        .d   (sq_sum),
        .q   (sq_dly)
    );

    v3a_sqrt u_sqrt (
        .clk (clk),
        .en  (en),
        .sq  (sq_dly),
        .len (len),
        .ovf (len_ovf)
    );

    always_comb
    begin
        out_next = fd;
        case (fd.op)
            v3a_pkg::OP_DIV:
            begin
                if (!fd.dz)
                begin
                    out_next.res_x      = dq[0];
                    out_next.res_y      = dq[1];
                    out_next.res_z      = dq[2];
                    out_next.res_scalar = '0;
                    out_next.ovf        = dovf[0] | dovf[1] | dovf[2];
                end
            end
            v3a_pkg::OP_LEN:
            begin
                out_next.res_scalar = len;
                out_next.ovf        = len_ovf;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign res_valid  = res_valid_reg;
    assign res_x      = out_reg.res_x;
    assign res_y      = out_reg.res_y;
    assign res_z      = out_reg.res_z;
    assign res_scalar = out_reg.res_scalar;
    assign div_zero   = out_reg.dz;
    assign overflow   = out_reg.ovf;

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && ready) |=> vld_reg[0])
        else $error("accepted beat did not enter the first stage");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved during a stall");

    a_dz: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && div_zero) |-> (res_scalar == '0 && !overflow))
        else $error("zero-divisor result carries a scalar or overflow");

    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[MERGE] && fd.op == v3a_pkg::OP_LEN)
            |-> (fd.res_x == '0 && fd.res_y == '0 && fd.res_z == '0 && !fd.dz))
        else $error("length beat carries a vector result");

endmodule
